// ===== src/fcz_pkg.sv =====
// ----------------------------------------------------------------------------
// fcz_pkg - shared definitions for the frame crop / zoom / flip engine
// Sizes, register indexes, status codes and the request/response words.
// ----------------------------------------------------------------------------
package fcz_pkg;

  localparam int MAX_SIDE    = 512;
  localparam int SIDE_W      = $clog2(MAX_SIDE) + 1;
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int PROD_W      = 2 * SIDE_W;
  localparam int SAMPLE_BITS = 8;
  localparam int PIX_W       = 3 * SAMPLE_BITS;
  localparam int ZOOM_LIMIT  = 500;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int STEP_W      = $clog2(SIDE_W);

  localparam logic [1:0] MODE_CROP   = 2'd0;
  localparam logic [1:0] MODE_ZOOM   = 2'd1;
  localparam logic [1:0] MODE_FLIP_H = 2'd2;
  localparam logic [1:0] MODE_FLIP_V = 2'd3;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_RIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_BOTTOM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR  = 3'd7;

  typedef enum logic [2:0] {
    ST_PIXEL       = 3'd0,
    ST_CROP_BOUNDS = 3'd1,
    ST_CROP_ORDER  = 3'd2,
    ST_ZERO_SCALE  = 3'd3,
    ST_TOO_LARGE   = 3'd4,
    ST_LOAD_OK     = 3'd5
  } status_t;

  typedef struct packed {
    logic                   command;
    logic [SAMPLE_BITS-1:0] red_in;
    logic [SAMPLE_BITS-1:0] green_in;
    logic [SAMPLE_BITS-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    status_t                status;
    logic [SAMPLE_BITS-1:0] red_out;
    logic [SAMPLE_BITS-1:0] green_out;
    logic [SAMPLE_BITS-1:0] blue_out;
    logic                   row_end;
    logic                   frame_end;
    logic [SIDE_W-1:0]      result_width;
    logic [SIDE_W-1:0]      result_height;
  } out_word_t;

  // zero acts as 1, anything above MAX_SIDE acts as MAX_SIDE
  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/frame_crop_zoom_flip_engine.sv =====
// ----------------------------------------------------------------------------
// frame_crop_zoom_flip_engine - frame store with crop, zoom and flip readout
//
// One word is taken on request when start is high and busy is low. A load
// word writes one RGB pixel into the frame store in raster order; a fetch
// word returns the next pixel of the result image (crop, pixel-replication
// zoom, horizontal or vertical flip, chosen by the mode register).
// Each word gives exactly one response word, shown for one cycle with done.
// The receiver cannot stall: done is a strobe and the response is dropped
// if not taken.
// A load word computes the frame area, then writes; a fetch word checks the
// registers, and in zoom mode two 10-step restoring dividers turn the
// output position into source coordinates. busy falls as done rises, so a
// new word may be taken in the cycle done is shown. The frame store is one
// single-port 512x512x24 RAM with a registered read; the address multiply
// and the read set the fetch length. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while idle, as
// the block does not enforce it. Reset clears control state and registers;
// the frame store holds garbage until loaded and needs no clearing pass.
// ----------------------------------------------------------------------------
module frame_crop_zoom_flip_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  fcz_pkg::in_word_t                   request,
  output logic                                done,
  output fcz_pkg::out_word_t                  response,
  input  logic                                cfg_we,
  input  logic [fcz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcz_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_LD_MUL  = 10'b00_0000_0010,
    S_LD_WR   = 10'b00_0000_0100,
    S_FT_CHK  = 10'b00_0000_1000,
    S_FT_SIZE = 10'b00_0001_0000,
    S_FT_DIV  = 10'b00_0010_0000,
    S_FT_SRC  = 10'b00_0100_0000,
    S_FT_MUL  = 10'b00_1000_0000,
    S_FT_RD   = 10'b01_0000_0000,
    S_FT_OUT  = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic [fcz_pkg::SIDE_W-1:0] rem;
    logic                       bit_q;
  } div_step_t;

  localparam int SW = fcz_pkg::SIDE_W;
  localparam int CW = fcz_pkg::COORD_W;
  localparam int AW = fcz_pkg::ADDR_W;
  localparam int PW = fcz_pkg::PROD_W;

  state_t state;

  // configuration
  logic [1:0]    mode;
  logic [SW-1:0] image_width;
  logic [SW-1:0] image_height;
  logic [CW-1:0] crop_left;
  logic [CW-1:0] crop_top;
  logic [CW-1:0] crop_right;
  logic [CW-1:0] crop_bottom;
  logic [SW-1:0] zoom_factor;

  // position state
  logic [AW-1:0] load_position;
  logic [SW-1:0] result_row;
  logic [SW-1:0] result_column;
  logic [fcz_pkg::STEP_W-1:0] step_cnt;

  // datapath
  fcz_pkg::in_word_t  req;
  fcz_pkg::out_word_t response_next;
  logic [PW-1:0]   area;
  logic [PW-1:0]   zoom_w;
  logic [PW-1:0]   zoom_h;
  logic [SW-1:0]   rw;
  logic [SW-1:0]   rh;
  logic [SW-1:0]   div_row_q;
  logic [SW-1:0]   div_row_r;
  logic [SW-1:0]   div_col_q;
  logic [SW-1:0]   div_col_r;
  logic [CW-1:0]   source_row;
  logic [CW-1:0]   source_column;
  logic [PW-1:0]   row_base;

  // frame store
  logic [fcz_pkg::PIX_W-1:0] frame_store [2**AW];
  logic [fcz_pkg::PIX_W-1:0] rd_data;
  logic                      mem_we;
  logic                      mem_re;
  logic [AW-1:0]             mem_addr;

  // combinational
  logic [SW-1:0]   w;
  logic [SW-1:0]   h;
  fcz_pkg::status_t chk_status;
  logic [SW-1:0]   rw_c;
  logic [SW-1:0]   rh_c;
  logic [SW-1:0]   row_fix;
  logic [SW-1:0]   col_fix;
  logic [CW-1:0]   sr_c;
  logic [CW-1:0]   sc_c;
  logic [AW-1:0]   ld_pos_fix;
  logic [PW-1:0]   ld_pos_inc;
  logic [AW-1:0]   load_position_next;
  logic            at_row_end;
  logic            at_frame_end;
  div_step_t       row_step;
  div_step_t       col_step;

  function automatic div_step_t div_step(input logic [SW-1:0] rem,
                                         input logic          bit_in,
                                         input logic [SW-1:0] divisor);
    logic [SW:0] sh;
    div_step_t   r;
    sh = {rem, bit_in};
    if (sh >= {1'b0, divisor}) begin
      r.rem   = SW'(sh - {1'b0, divisor});
      r.bit_q = 1'b1;
    end else begin
      r.rem   = sh[SW-1:0];
      r.bit_q = 1'b0;
    end
    return r;
  endfunction

  assign busy = (state != S_IDLE);
  assign w    = fcz_pkg::side_of(image_width);
  assign h    = fcz_pkg::side_of(image_height);

  always_comb begin
    chk_status = fcz_pkg::ST_PIXEL;
    rw_c       = w;
    rh_c       = h;
    case (mode)
      fcz_pkg::MODE_CROP: begin
        if ({1'b0, crop_right} >= w || {1'b0, crop_bottom} >= h) begin
          chk_status = fcz_pkg::ST_CROP_BOUNDS;
        end else if (crop_right < crop_left || crop_bottom < crop_top) begin
          chk_status = fcz_pkg::ST_CROP_ORDER;
        end
        rw_c = SW'({1'b0, crop_right} - {1'b0, crop_left}) + SW'(1);
        rh_c = SW'({1'b0, crop_bottom} - {1'b0, crop_top}) + SW'(1);
      end
      fcz_pkg::MODE_ZOOM: begin
        if (zoom_factor == '0) begin
          chk_status = fcz_pkg::ST_ZERO_SCALE;
        end else if (zoom_w > PW'(fcz_pkg::ZOOM_LIMIT) ||
                     zoom_h > PW'(fcz_pkg::ZOOM_LIMIT)) begin
          chk_status = fcz_pkg::ST_TOO_LARGE;
        end
        rw_c = zoom_w[SW-1:0];
        rh_c = zoom_h[SW-1:0];
      end
      default: begin
        rw_c = w;
        rh_c = h;
      end
    endcase
  end

  always_comb begin
    if (result_row >= rh_c || result_column >= rw_c) begin
      row_fix = '0;
      col_fix = '0;
    end else begin
      row_fix = result_row;
      col_fix = result_column;
    end
  end

  assign row_step = div_step(div_row_r, div_row_q[SW-1], zoom_factor);
  assign col_step = div_step(div_col_r, div_col_q[SW-1], zoom_factor);

  always_comb begin
    case (mode)
      fcz_pkg::MODE_CROP: begin
        sr_c = CW'({1'b0, crop_top} + result_row);
        sc_c = CW'({1'b0, crop_left} + result_column);
      end
      fcz_pkg::MODE_ZOOM: begin
        sr_c = div_row_q[CW-1:0];
        sc_c = div_col_q[CW-1:0];
      end
      fcz_pkg::MODE_FLIP_H: begin
        sr_c = result_row[CW-1:0];
        sc_c = CW'(w - SW'(1) - result_column);
      end
      default: begin
        sr_c = CW'(h - SW'(1) - result_row);
        sc_c = result_column[CW-1:0];
      end
    endcase
  end

  always_comb begin
    ld_pos_fix = ({1'b0, load_position} >= area[AW:0]) ? '0 : load_position;
    ld_pos_inc = PW'(ld_pos_fix) + PW'(1);
    load_position_next = (ld_pos_inc >= area) ? '0 : ld_pos_inc[AW-1:0];
  end

  assign at_row_end   = (result_column == rw - SW'(1));
  assign at_frame_end = at_row_end && (result_row == rh - SW'(1));

  assign mem_we   = (state == S_LD_WR);
  assign mem_re   = (state == S_FT_RD);
  assign mem_addr = mem_we ? ld_pos_fix
                           : AW'(row_base[AW-1:0] + AW'(source_column));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_addr] <= {req.red_in, req.green_in, req.blue_in};
    end
    if (mem_re) begin
      rd_data <= frame_store[mem_addr];
    end
  end

  always_comb begin
    response_next = '0;
    case (state)
      S_LD_WR: begin
        response_next.status = fcz_pkg::ST_LOAD_OK;
      end
      S_FT_SIZE: begin
        response_next.status = chk_status;
      end
      S_FT_OUT: begin
        response_next.status        = fcz_pkg::ST_PIXEL;
        response_next.red_out       = rd_data[3*fcz_pkg::SAMPLE_BITS-1:2*fcz_pkg::SAMPLE_BITS];
        response_next.green_out     = rd_data[2*fcz_pkg::SAMPLE_BITS-1:fcz_pkg::SAMPLE_BITS];
        response_next.blue_out      = rd_data[fcz_pkg::SAMPLE_BITS-1:0];
        response_next.row_end       = at_row_end;
        response_next.frame_end     = at_frame_end;
        response_next.result_width  = rw;
        response_next.result_height = rh;
      end
      default: begin
        response_next = '0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      load_position <= '0;
      result_row    <= '0;
      result_column <= '0;
      step_cnt      <= '0;
      mode          <= fcz_pkg::MODE_CROP;
      image_width   <= SW'(1);
      image_height  <= SW'(1);
      crop_left     <= '0;
      crop_top      <= '0;
      crop_right    <= '0;
      crop_bottom   <= '0;
      zoom_factor   <= SW'(1);
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          fcz_pkg::REG_MODE:         mode         <= cfg_data[1:0];
          fcz_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[SW-1:0];
          fcz_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[SW-1:0];
          fcz_pkg::REG_CROP_LEFT:    crop_left    <= cfg_data[CW-1:0];
          fcz_pkg::REG_CROP_TOP:     crop_top     <= cfg_data[CW-1:0];
          fcz_pkg::REG_CROP_RIGHT:   crop_right   <= cfg_data[CW-1:0];
          fcz_pkg::REG_CROP_BOTTOM:  crop_bottom  <= cfg_data[CW-1:0];
          fcz_pkg::REG_ZOOM_FACTOR:  zoom_factor  <= cfg_data[SW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= (request.command == fcz_pkg::CMD_LOAD) ? S_LD_MUL : S_FT_CHK;
          end
        end
        S_LD_MUL: begin
          state <= S_LD_WR;
        end
        S_LD_WR: begin
          load_position <= load_position_next;
          result_row    <= '0;
          result_column <= '0;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_FT_CHK: begin
          state <= S_FT_SIZE;
        end
        S_FT_SIZE: begin
          if (chk_status != fcz_pkg::ST_PIXEL) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            result_row    <= row_fix;
            result_column <= col_fix;
            step_cnt      <= '0;
            state         <= (mode == fcz_pkg::MODE_ZOOM) ? S_FT_DIV : S_FT_SRC;
          end
        end
        S_FT_DIV: begin
          step_cnt <= step_cnt + fcz_pkg::STEP_W'(1);
          if (step_cnt == fcz_pkg::STEP_W'(SW - 1)) begin
            state <= S_FT_SRC;
          end
        end
        S_FT_SRC: begin
          state <= S_FT_MUL;
        end
        S_FT_MUL: begin
          state <= S_FT_RD;
        end
        S_FT_RD: begin
          state <= S_FT_OUT;
        end
        S_FT_OUT: begin
          done <= 1'b1;
          if (at_row_end) begin
            result_column <= '0;
            result_row    <= (result_row == rh - SW'(1)) ? '0 : result_row + SW'(1);
          end else begin
            result_column <= result_column + SW'(1);
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req <= request;
    end
    if (state == S_LD_MUL) begin
      area <= PW'(w) * PW'(h);
    end
    if (state == S_FT_CHK) begin
      zoom_w <= PW'(w) * PW'(zoom_factor);
      zoom_h <= PW'(h) * PW'(zoom_factor);
    end
    if (state == S_FT_SIZE) begin
      rw        <= rw_c;
      rh        <= rh_c;
      div_row_q <= row_fix;
      div_col_q <= col_fix;
      div_row_r <= '0;
      div_col_r <= '0;
    end
    if (state == S_FT_DIV) begin
      div_row_r <= row_step.rem;
      div_row_q <= {div_row_q[SW-2:0], row_step.bit_q};
      div_col_r <= col_step.rem;
      div_col_q <= {div_col_q[SW-2:0], col_step.bit_q};
    end
    if (state == S_FT_SRC) begin
      source_row    <= sr_c;
      source_column <= sc_c;
    end
    if (state == S_FT_MUL) begin
      row_base <= PW'(source_row) * PW'(w);
    end
    if (state == S_LD_WR || state == S_FT_OUT ||
        (state == S_FT_SIZE && chk_status != fcz_pkg::ST_PIXEL)) begin
      response <= response_next;
    end
  end

  a_done_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (response.status == fcz_pkg::ST_CROP_BOUNDS ||
              response.status == fcz_pkg::ST_CROP_ORDER ||
              response.status == fcz_pkg::ST_ZERO_SCALE ||
              response.status == fcz_pkg::ST_TOO_LARGE))
    |-> (response.red_out == '0 && response.green_out == '0 &&
         response.blue_out == '0 && !response.row_end && !response.frame_end &&
         response.result_width == '0 && response.result_height == '0))
    else $error("error word carries pixel data");

  a_pixel_size: assert property (@(posedge clk) disable iff (rst)
    (done && response.status == fcz_pkg::ST_PIXEL)
    |-> (response.result_width != '0 && response.result_height != '0))
    else $error("pixel word with empty result size");

  a_frame_end_row: assert property (@(posedge clk) disable iff (rst)
    (done && response.frame_end) |-> response.row_end)
    else $error("frame end without row end");

endmodule
